// ----- rtl/dns_a_query_fixed_responder_macros.svh -----
// ============================================================================
// DNS A query fixed responder - assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ============================================================================
`ifndef DNS_A_QUERY_FIXED_RESPONDER_MACROS_SVH
`define DNS_A_QUERY_FIXED_RESPONDER_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked on every clock edge outside reset
`define DQR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset
`define DQR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DQR_ASSERT(label, clk, rst_n, prop, msg)
`define DQR_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/dqr_pkg.sv -----
// ============================================================================
// dqr_pkg
// Shared types, constants and the answer record table for the DNS responder.
// ============================================================================
`timescale 1ns / 1ps

package dqr_pkg;

    // Packet limits
    localparam int MAX_PACKET = 512;
    localparam int POS_W      = $clog2(MAX_PACKET + 1);
    localparam int HEADER_LEN = 12;

    // Header byte offsets that get rewritten or inspected
    localparam int POS_FLAGS    = 2;
    localparam int POS_QD_HI    = 4;
    localparam int POS_QD_LO    = 5;
    localparam int POS_AN_HI    = 6;
    localparam int POS_AN_LO    = 7;

    localparam logic [15:0] QTYPE_A      = 16'h0001;
    localparam logic [7:0]  PTR_MASK     = 8'hC0;
    localparam logic [7:0]  RESP_BIT     = 8'h80;
    localparam logic [7:0]  ANCOUNT_LO   = 8'h01;

    // Answer record: 12 fixed bytes then the 4 address bytes
    localparam int ANS_LEN    = 16;
    localparam int ANS_IDX_W  = $clog2(ANS_LEN);
    localparam int ANS_FIXED  = 12;

    localparam logic [7:0] ANS_TABLE [ANS_FIXED] = '{
        8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
        8'h00, 8'h00, 8'h27, 8'h10, 8'h00, 8'h04
    };

    // Question parser phases
    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_LEN     = 7'b0000010,
        PH_BODY    = 7'b0000100,
        PH_PTR     = 7'b0001000,
        PH_TYPE_HI = 7'b0010000,
        PH_TYPE_LO = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    // What one accepted query byte asks the output stage to do
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       last;
        logic       short_pkt;
        logic       start_ans;
    } result_t;

    // One byte of the appended answer record
    function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                               input logic [31:0] ipv4);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd12:   b = ipv4[31:24];
            4'd13:   b = ipv4[23:16];
            4'd14:   b = ipv4[15:8];
            4'd15:   b = ipv4[7:0];
            default: b = ANS_TABLE[idx];
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/dqr_parser.sv -----
// ============================================================================
// dqr_parser
// Header rewrite and question parse for one query byte per transaction.
// ============================================================================
`timescale 1ns / 1ps

module dqr_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output dqr_pkg::result_t res
);
    import dqr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       lbl_reg, lbl_next;
    logic [15:0]      qtype_reg, qtype_next;
    logic             hasq_reg, hasq_next;

    logic             kept;
    logic [7:0]       ob;
    logic             short_pkt;
    logic             ans;

    // Next packet state and the result for this byte
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        lbl_next   = lbl_reg;
        qtype_next = qtype_reg;
        hasq_next  = hasq_reg;

        kept = (pos_reg < POS_W'(MAX_PACKET));

        // header field rewrite
        ob = in_byte;
        if (pos_reg == POS_W'(POS_FLAGS))
        begin
            ob = in_byte | RESP_BIT;
        end
        else if (pos_reg == POS_W'(POS_AN_HI))
        begin
            ob = 8'h00;
        end
        else if (pos_reg == POS_W'(POS_AN_LO))
        begin
            ob = ANCOUNT_LO;
        end

        if (kept)
        begin
            if ((pos_reg == POS_W'(POS_QD_HI) || pos_reg == POS_W'(POS_QD_LO)) &&
                in_byte != 8'h00)
            begin
                hasq_next = 1'b1;
            end

            // question name / type walk
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_W'(HEADER_LEN - 1))
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (in_byte == 8'h00)
                    begin
                        phase_next = PH_TYPE_HI;
                    end
                    else if ((in_byte & PTR_MASK) != 8'h00)
                    begin
                        phase_next = PH_PTR;
                    end
                    else
                    begin
                        lbl_next   = in_byte;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    lbl_next = lbl_reg - 8'd1;
                    if (lbl_reg == 8'd1)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_PTR:
                begin
                    phase_next = PH_TYPE_HI;
                end
                PH_TYPE_HI:
                begin
                    qtype_next = {in_byte, 8'h00};
                    phase_next = PH_TYPE_LO;
                end
                PH_TYPE_LO:
                begin
                    qtype_next = {qtype_reg[15:8], in_byte};
                    phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase

            pos_next = pos_reg + POS_W'(1);
        end

        short_pkt = (pos_next < POS_W'(HEADER_LEN));
        ans = !short_pkt && hasq_next && (phase_next == PH_DONE) &&
              (qtype_next == QTYPE_A);

        // result for the output stage
        res.emit      = kept || (in_last && !ans);
        res.data      = kept ? ob : 8'h00;
        res.last      = in_last && !ans;
        res.short_pkt = in_last && !ans && short_pkt;
        res.start_ans = in_last && ans;
    end

    // Packet state; cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            lbl_reg   <= '0;
            qtype_reg <= '0;
            hasq_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            if (in_last)
            begin
                pos_reg   <= '0;
                phase_reg <= PH_HEADER;
                lbl_reg   <= '0;
                qtype_reg <= '0;
                hasq_reg  <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                lbl_reg   <= lbl_next;
                qtype_reg <= qtype_next;
                hasq_reg  <= hasq_next;
            end
        end
    end

endmodule

// ----- rtl/dqr_out_stage.sv -----
// ============================================================================
// dqr_out_stage
// Result register and answer record sequencer.
// ============================================================================
`timescale 1ns / 1ps

`include "dns_a_query_fixed_responder_macros.svh"

module dqr_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  dqr_pkg::result_t res,
    input  logic [31:0]      answer_ipv4,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             short_packet,
    output logic             answered,
    output logic             can_take,
    output logic             ans_busy
);
    import dqr_pkg::*;

    logic                 valid_reg, valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic                 short_reg, short_next;
    logic                 ansd_reg, ansd_next;
    logic                 active_reg, active_next;
    logic [ANS_IDX_W-1:0] idx_reg, idx_next;
    logic                 idx_end;
    logic                 can_load;

    assign can_load = !valid_reg || out_ready;
    assign idx_end  = (idx_reg == ANS_IDX_W'(ANS_LEN - 1));

    // Load from the parser, else from the answer sequencer, else drain
    always_comb
    begin
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        short_next  = short_reg;
        ansd_next   = ansd_reg;
        active_next = active_reg;
        idx_next    = idx_reg;

        if (in_fire)
        begin
            valid_next = res.emit;
            byte_next  = res.data;
            last_next  = res.last;
            short_next = res.short_pkt;
            ansd_next  = 1'b0;
            if (res.start_ans)
            begin
                active_next = 1'b1;
                idx_next    = '0;
            end
        end
        else if (active_reg && can_load)
        begin
            valid_next = 1'b1;
            byte_next  = answer_byte(idx_reg, answer_ipv4);
            last_next  = idx_end;
            short_next = 1'b0;
            ansd_next  = idx_end;
            idx_next   = idx_reg + ANS_IDX_W'(1);
            if (idx_end)
            begin
                active_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        short_reg <= short_next;
        ansd_reg  <= ansd_next;
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign short_packet = short_reg;
    assign answered     = ansd_reg;
    assign can_take     = can_load;
    assign ans_busy     = active_reg;

    // Checks
    `DQR_ASSERT(a_ans_start, clk, rst_n, (in_fire && res.start_ans) |=> active_reg, "answer sequencer did not start")
    `DQR_ASSERT(a_ans_end, clk, rst_n, (active_reg && can_load && idx_end) |=> (!active_reg && valid_reg && last_reg && ansd_reg), "answer record did not close the reply")
    `DQR_ASSERT_NEVER(a_no_input_in_ans, clk, rst_n, in_fire && active_reg, "query byte taken while appending an answer")
    `DQR_ASSERT_NEVER(a_flags_need_last, clk, rst_n, valid_reg && (short_reg || ansd_reg) && !last_reg, "status flag on a non-final reply byte")

endmodule

// ----- rtl/dns_a_query_fixed_responder.sv -----
// ============================================================================
// dns_a_query_fixed_responder
// Echoes a DNS query as a reply and appends a fixed A answer when asked.
// Each accepted query byte is registered and shown as its reply byte next cycle.
// Throughput: one byte per cycle while out_ready is high; an answered query
//   then adds 16 bytes at that rate from the answer sequencer, input held off.
// Reset: asynchronous, active low; clears packet state and answer_ipv4.
// ============================================================================
`timescale 1ns / 1ps

module dns_a_query_fixed_responder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        short_packet,
    output logic        answered
);
    import dqr_pkg::*;

    logic [31:0] ipv4_reg;
    logic        in_fire;
    logic        can_take;
    logic        ans_busy;
    result_t     res;

    // Address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_reg <= '0;
        end
        else if (cfg_we)
        begin
            ipv4_reg <= cfg_wdata;
        end
    end

    assign in_ready = can_take && !ans_busy;
    assign in_fire  = in_valid && in_ready;

    dqr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_byte (in_byte),
        .in_last (in_last),
        .res     (res)
    );

    dqr_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .res          (res),
        .answer_ipv4  (ipv4_reg),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .short_packet (short_packet),
        .answered     (answered),
        .can_take     (can_take),
        .ans_busy     (ans_busy)
    );

endmodule
